[src/twofish_block_cipher_core_assert.svh]
// Assertion macros for the Twofish core.
`ifndef TWOFISH_BLOCK_CIPHER_CORE_ASSERT_SVH
`define TWOFISH_BLOCK_CIPHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/tf_pkg.sv]
// Types, constants and GF/q functions shared by the Twofish core.
package tf_pkg;
	localparam int Rounds = 16;
	localparam int SubkeyCount = 40;
	localparam logic [8:0] RsPoly = 9'h14D;
	localparam logic [7:0] MdsPolyLow = 8'h69;
	localparam logic [31:0] Rho = 32'h02020202;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3,
		REG_KEY_SIZE = 3'd4, REG_CHAIN_MODE = 3'd5, REG_IV_LOW = 3'd6, REG_IV_HIGH = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RS, ST_KEYGEN, ST_WHITE_IN, ST_ROUND, ST_WHITE_OUT, ST_DONE
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic        restart_chain;
		logic        last_block_in;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
		logic        last_block_out;
	} out_item_t;

	// control from the sequencer to the shared g/h unit
	typedef struct packed {
		logic [2:0] kw;
	} h_ctrl_t;

	function automatic logic [3:0] ror4(input logic [3:0] v);
		return {v[0], v[3:1]};
	endfunction

	function automatic logic [3:0] qt(input logic p, input logic [1:0] t, input logic [3:0] x);
		logic [63:0] row;
		unique case ({p, t})
			3'd0: row = 64'h4ACE95B023F6D718;
			3'd1: row = 64'hD9076A4F53218BCE;
			3'd2: row = 64'h17423F8C09D6E5AB;
			3'd3: row = 64'hAC5803B9E6214F7D;
			3'd4: row = 64'h5CA04913E67FDB82;
			3'd5: row = 64'h809F5AD673C4B2E1;
			3'd6: row = 64'hF3B28DE0A96157C4;
			default: row = 64'hA802F746ED3C159B;
		endcase
		return row[{x, 2'b00} +: 4];
	endfunction

	function automatic logic [7:0] qperm(input logic p, input logic [7:0] x);
		logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
		a0 = x[7:4];
		b0 = x[3:0];
		a1 = a0 ^ b0;
		b1 = a0 ^ ror4(b0) ^ {a0[0], 3'b000};
		a2 = qt(p, 2'd0, a1);
		b2 = qt(p, 2'd1, b1);
		a3 = a2 ^ b2;
		b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
		a4 = qt(p, 2'd2, a3);
		b4 = qt(p, 2'd3, b3);
		return {b4, a4};
	endfunction

	function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p, aa;
		p = '0;
		aa = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p = p ^ aa;
			aa = aa[7] ? ({aa[6:0], 1'b0} ^ MdsPolyLow) : {aa[6:0], 1'b0};
		end
		return p;
	endfunction

	function automatic logic [31:0] rs_step(input logic [31:0] x);
		logic [7:0] b, g2, g3;
		b = x[31:24];
		g2 = {b[6:0], 1'b0} ^ (b[7] ? RsPoly[7:0] : 8'h00);
		g3 = {1'b0, b[7:1]} ^ (b[0] ? RsPoly[8:1] : 8'h00) ^ g2;
		return {x[23:0], 8'h00} ^ {g3, g2, g3, b};
	endfunction
endpackage

[src/tf_h_unit.sv]
// Shared h function: key-dependent q/XOR layers and the MDS multiply.
module tf_h_unit (
	input  logic [31:0]     x,
	input  logic [31:0]     l0,
	input  logic [31:0]     l1,
	input  logic [31:0]     l2,
	input  logic [31:0]     l3,
	input  tf_pkg::h_ctrl_t ctrl,
	output logic [31:0]     z
);
	import tf_pkg::*;

	logic [7:0] y0, y1, y2, y3;
	logic [7:0] m [4];

	always_comb begin
		y0 = x[7:0];
		y1 = x[15:8];
		y2 = x[23:16];
		y3 = x[31:24];
		if (ctrl.kw >= 3'd4) begin
			y0 = qperm(1'b1, y0) ^ l3[7:0];
			y1 = qperm(1'b0, y1) ^ l3[15:8];
			y2 = qperm(1'b0, y2) ^ l3[23:16];
			y3 = qperm(1'b1, y3) ^ l3[31:24];
		end
		if (ctrl.kw >= 3'd3) begin
			y0 = qperm(1'b1, y0) ^ l2[7:0];
			y1 = qperm(1'b1, y1) ^ l2[15:8];
			y2 = qperm(1'b0, y2) ^ l2[23:16];
			y3 = qperm(1'b0, y3) ^ l2[31:24];
		end
		m[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y0) ^ l1[7:0]) ^ l0[7:0]);
		m[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y1) ^ l1[15:8]) ^ l0[15:8]);
		m[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y2) ^ l1[23:16]) ^ l0[23:16]);
		m[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y3) ^ l1[31:24]) ^ l0[31:24]);
		z[7:0]   = m[0] ^ gfmul(8'hEF, m[1]) ^ gfmul(8'h5B, m[2]) ^ gfmul(8'h5B, m[3]);
		z[15:8]  = gfmul(8'h5B, m[0]) ^ gfmul(8'hEF, m[1]) ^ gfmul(8'hEF, m[2]) ^ m[3];
		z[23:16] = gfmul(8'hEF, m[0]) ^ gfmul(8'h5B, m[1]) ^ m[2] ^ gfmul(8'hEF, m[3]);
		z[31:24] = gfmul(8'hEF, m[0]) ^ m[1] ^ gfmul(8'hEF, m[2]) ^ gfmul(8'h5B, m[3]);
	end
endmodule

[src/twofish_block_cipher_core.sv]
// Top level of the Twofish ECB/CBC block cipher core.
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | tf_pkg::in_item_t
//  out     | output    | valid / stall | tf_pkg::out_item_t
//  cfg     | input     | valid / ready | index, data
// A block goes through these steps from one accepted transaction to the next: accept, whitening in,
// 16 rounds (in each the shared h unit gives t0, then t1), whitening out, result.
// After a key change the first block first adds the Reed-Solomon remainders (eight
// steps for each of the four key words) and then subkey generation.
// Reset loads the chain value from the zero IV; the result register holds under out_stall
// and no transaction is taken until it drains.
`include "twofish_block_cipher_core_assert.svh"
module twofish_block_cipher_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tf_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output tf_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import tf_pkg::*;

	logic [63:0] key_q [4];
	logic [1:0]  key_size_q;
	logic        chain_mode_q;
	logic [63:0] iv_lo_q, iv_hi_q;
	logic        keys_ready_q;
	logic [63:0] chain_lo_q, chain_hi_q;
	// whitening subkeys 0..7 and round subkeys 8..39
	logic [31:0] wkey_q [8];
	logic [31:0] rkey_q [SubkeyCount - 8];
	logic [31:0] sbox_q [4];

	state_t      state_q, state_d;
	logic [5:0]  cnt_q;
	logic        phase_q;
	logic [31:0] x_q [4];
	logic [31:0] ta_q;
	logic        dec_q, last_q;
	logic [63:0] blk_lo_q, blk_hi_q;
	logic [31:0] rs_q;
	logic [2:0]  kw;
	logic        in_acc, out_acc, cfg_acc;

	logic [31:0]     h_x, h_l0, h_l1, h_l2, h_l3, h_z;
	h_ctrl_t         h_ctrl;

	assign kw = (key_size_q == 2'd0) ? 3'd2 : (key_size_q == 2'd1) ? 3'd3 : 3'd4;
	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_DONE);
	assign out_acc = out_valid && !out_stall;

	// round index: enc counts up, dec counts down
	logic [3:0]  rnd;
	assign rnd = dec_q ? 4'(15 - cnt_q[3:0]) : cnt_q[3:0];

	// key split into even/odd words
	logic [31:0] me [4], mo [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			me[i] = key_q[i][31:0];
			mo[i] = key_q[i][63:32];
		end
	end

	always_comb begin
		h_ctrl.kw = kw;
		if (state_q == ST_ROUND) begin
			h_x = phase_q ? {x_q[1][23:0], x_q[1][31:24]} : x_q[0];
			h_l0 = sbox_q[0];
			h_l1 = sbox_q[1];
			h_l2 = sbox_q[2];
			h_l3 = sbox_q[3];
		end else if (!phase_q) begin
			h_x = 32'(cnt_q) * Rho;
			h_l0 = me[0];
			h_l1 = me[1];
			h_l2 = me[2];
			h_l3 = me[3];
		end else begin
			h_x = 32'(cnt_q) * Rho + (Rho >> 1);
			h_l0 = mo[0];
			h_l1 = mo[1];
			h_l2 = mo[2];
			h_l3 = mo[3];
		end
	end

	tf_h_unit u_h (
		.x(h_x), .l0(h_l0), .l1(h_l1), .l2(h_l2), .l3(h_l3), .ctrl(h_ctrl), .z(h_z)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc)
				state_d = keys_ready_q ? ST_WHITE_IN : ST_RS;
			ST_RS: if (cnt_q[4:0] == 5'd27 && phase_q)
				state_d = ST_KEYGEN;
			ST_KEYGEN: if (cnt_q == 6'd19 && phase_q)
				state_d = ST_WHITE_IN;
			ST_WHITE_IN: state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 6'(Rounds - 1) && phase_q)
				state_d = ST_WHITE_OUT;
			ST_WHITE_OUT: state_d = ST_DONE;
			ST_DONE: if (out_acc)
				state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RS: cnt[4:3] = key word, cnt[2:0] = step; phase toggles after every fourth step
	logic [31:0] rs_next;
	logic [31:0] f0, f1, x2n, x3n, e2, e3;
	logic [1:0]  rsw;
	assign rsw = cnt_q[4:3];
	always_comb begin
		rs_next = rs_step(rs_q);
		f0 = ta_q + h_z + rkey_q[{rnd, 1'b0}];
		f1 = ta_q + {h_z[30:0], 1'b0} + rkey_q[{rnd, 1'b1}];
		e2 = x_q[2] ^ f0;
		e3 = x_q[3] ^ f1;
		if (!dec_q) begin
			x2n = {e2[0], e2[31:1]};
			x3n = {x_q[3][30:0], x_q[3][31]} ^ f1;
		end else begin
			x2n = {x_q[2][30:0], x_q[2][31]} ^ f0;
			x3n = {e3[0], e3[31:1]};
		end
	end

	logic [31:0] sb, sk;
	assign sb = ta_q + {h_z[23:0], h_z[31:24]};
	assign sk = ta_q + {h_z[22:0], h_z[31:24], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			phase_q <= 1'b0;
			keys_ready_q <= 1'b0;
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
			key_size_q <= '0;
			chain_mode_q <= 1'b0;
			iv_lo_q <= '0;
			iv_hi_q <= '0;
			chain_lo_q <= '0;
			chain_hi_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				unique case (reg_idx_t'(cfg_index)) inside
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_SIZE: begin
						key_size_q <= cfg_data[1:0];
						keys_ready_q <= 1'b0;
					end
					REG_CHAIN_MODE: chain_mode_q <= cfg_data[0];
					REG_IV_LOW: iv_lo_q <= cfg_data;
					REG_IV_HIGH: iv_hi_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					cnt_q <= '0;
					phase_q <= 1'b0;
					if (in_data.restart_chain) begin
						chain_lo_q <= iv_lo_q;
						chain_hi_q <= iv_hi_q;
					end
				end
				ST_RS: begin
					// step counter low bits: 0..3 odd word, phase 1 adds even word
					if (cnt_q[2:0] == 3'd0 && !phase_q)
						rs_q <= rs_step(mo[rsw]);
					else if (cnt_q[2:0] == 3'd3 && !phase_q) begin
						rs_q <= rs_next;
						phase_q <= 1'b1;
					end else if (cnt_q[2:0] == 3'd0 && phase_q)
						rs_q <= rs_step(rs_q ^ me[rsw]);
					else
						rs_q <= rs_next;
					if (phase_q && cnt_q[2:0] == 3'd3) begin
						if (3'(rsw) < kw)
							sbox_q[2'(kw - 3'd1 - 3'(rsw))] <= rs_next;
						cnt_q <= {cnt_q[5], cnt_q[4:3] + 2'd1, 3'd0};
						phase_q <= 1'b0;
						if (rsw == 2'd3) begin
							cnt_q <= '0;
							for (int i = 0; i < 4; i++)
								if (3'(i) >= kw)
									sbox_q[i] <= '0;
						end
					end else if (!(cnt_q[2:0] == 3'd3 && !phase_q))
						cnt_q <= cnt_q + 6'd1;
					else
						cnt_q <= {cnt_q[5:3], 3'd0};
				end
				ST_KEYGEN: begin
					phase_q <= !phase_q;
					if (!phase_q)
						ta_q <= h_z;
					else begin
						if (cnt_q < 6'd4) begin
							wkey_q[{cnt_q[1:0], 1'b0}] <= sb;
							wkey_q[{cnt_q[1:0], 1'b1}] <= {sk[22:0], sk[31:23]};
						end else begin
							rkey_q[{4'(cnt_q - 6'd4), 1'b0}] <= sb;
							rkey_q[{4'(cnt_q - 6'd4), 1'b1}] <= {sk[22:0], sk[31:23]};
						end
						cnt_q <= (cnt_q == 6'd19) ? 6'd0 : cnt_q + 6'd1;
						if (cnt_q == 6'd19)
							keys_ready_q <= 1'b1;
					end
				end
				ST_WHITE_IN: begin
					if (!dec_q) begin
						x_q[0] <= blk_lo_q[31:0] ^ (chain_mode_q ? chain_lo_q[31:0] : '0)
							^ wkey_q[0];
						x_q[1] <= blk_lo_q[63:32] ^ (chain_mode_q ? chain_lo_q[63:32] : '0)
							^ wkey_q[1];
						x_q[2] <= blk_hi_q[31:0] ^ (chain_mode_q ? chain_hi_q[31:0] : '0)
							^ wkey_q[2];
						x_q[3] <= blk_hi_q[63:32] ^ (chain_mode_q ? chain_hi_q[63:32] : '0)
							^ wkey_q[3];
					end else begin
						x_q[0] <= blk_lo_q[31:0] ^ wkey_q[4];
						x_q[1] <= blk_lo_q[63:32] ^ wkey_q[5];
						x_q[2] <= blk_hi_q[31:0] ^ wkey_q[6];
						x_q[3] <= blk_hi_q[63:32] ^ wkey_q[7];
					end
				end
				ST_ROUND: begin
					phase_q <= !phase_q;
					if (!phase_q)
						ta_q <= h_z;
					else begin
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'(Rounds - 1)) begin
							x_q[2] <= x2n;
							x_q[3] <= x3n;
						end else begin
							// advance and swap halves
							x_q[0] <= x2n;
							x_q[1] <= x3n;
							x_q[2] <= x_q[0];
							x_q[3] <= x_q[1];
						end
					end
				end
				ST_WHITE_OUT: begin
					logic [63:0] rl, rh;
					if (!dec_q) begin
						rl = {x_q[1] ^ wkey_q[5], x_q[0] ^ wkey_q[4]};
						rh = {x_q[3] ^ wkey_q[7], x_q[2] ^ wkey_q[6]};
					end else begin
						rl = {x_q[1] ^ wkey_q[1], x_q[0] ^ wkey_q[0]}
							^ (chain_mode_q ? chain_lo_q : '0);
						rh = {x_q[3] ^ wkey_q[3], x_q[2] ^ wkey_q[2]}
							^ (chain_mode_q ? chain_hi_q : '0);
					end
					out_data.result_low <= rl;
					out_data.result_high <= rh;
					out_data.last_block_out <= last_q;
					if (chain_mode_q) begin
						chain_lo_q <= dec_q ? blk_lo_q : rl;
						chain_hi_q <= dec_q ? blk_hi_q : rh;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dec_q <= in_data.operation;
			blk_lo_q <= in_data.block_low;
			blk_hi_q <= in_data.block_high;
			last_q <= in_data.last_block_in;
		end
	end

	`TF_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_acc, in_stall)
	`TF_ASSERT_IMPL(a_round_keys, clk, arst_n, state_q == ST_ROUND, keys_ready_q)
	`TF_ASSERT_NEXT(a_done_hold, clk, arst_n, out_valid && out_stall, out_valid)
endmodule
